FILE: hw/rtl/multi_queue_byte_ring_buffer_assert.svh
// Assertion macros for the ring buffer RTL, included by mqrb_dp.
// No dependencies; include inside a module body after its signals.
`ifndef MULTI_QUEUE_BYTE_RING_BUFFER_ASSERT_SVH
`define MULTI_QUEUE_BYTE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqrb: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MQRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqrb: assertion failed");

`endif

FILE: hw/rtl/mqrb_pkg.sv
// Shared types and constants for the multi-queue byte ring buffer.
// No dependencies.
package mqrb_pkg;

    localparam int CMD_W       = 2;
    localparam int QID_W       = 2;
    localparam int LEN_W       = 4;
    localparam int DATA_W      = 64;
    localparam int SIZE_W      = 7;
    localparam int NUM_SIZE_REGS = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 72;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    typedef struct packed {
        logic load;
        logic check;
        logic push_step;
        logic pop_step;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic go_push;
        logic go_pop;
        logic last;
        logic out_busy;
    } t_ctrl_sts;

endpackage

FILE: hw/rtl/mqrb_ctrl.sv
// Sequencer for one command: accept, check, byte steps, drain, result.
// Depends on mqrb_pkg.
module mqrb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  mqrb_pkg::t_ctrl_sts  i_sts,
    output mqrb_pkg::t_ctrl_cmd  o_cmd
);
    import mqrb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PUSH  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = i_rst_n;
                if (i_rst_n && i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.go_push) begin
                    n_state = S_PUSH;
                end else if (i_sts.go_pop) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PUSH: begin
                o_cmd.push_step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_FIN;
                end
            end
            S_POP: begin
                o_cmd.pop_step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mqrb_dp.sv
// Datapath: size registers, queue positions, byte store and result register.
// Depends on mqrb_pkg and multi_queue_byte_ring_buffer_assert.svh.
module mqrb_dp #(
    parameter int NUM_QUEUES      = 4,
    parameter int QUEUE_DEPTH     = 64,
    parameter int MAX_BLOCK_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [mqrb_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic [mqrb_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mqrb_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [mqrb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mqrb_pkg::SIZE_W-1:0]         i_cfg_data,
    input  mqrb_pkg::t_ctrl_cmd                 i_cmd,
    output mqrb_pkg::t_ctrl_sts                 o_sts
);
    import mqrb_pkg::*;

    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int SPW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW  = (SPW > SIZE_W) ? SPW : SIZE_W;
    localparam int LW  = (SPW > LEN_W) ? SPW : LEN_W;
    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int TOT = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW  = $clog2(TOT);

    logic [SIZE_W-1:0] r_size [NUM_SIZE_REGS];
    logic [PW-1:0]     r_wr   [NUM_QUEUES];
    logic [PW-1:0]     r_rd   [NUM_QUEUES];
    logic              r_full [NUM_QUEUES];
    logic [7:0]        r_mem  [TOT];

    logic [CMD_W-1:0]  r_cmd;
    logic [QID_W-1:0]  r_q;
    logic [LEN_W-1:0]  r_len;
    logic [DATA_W-1:0] r_data;
    logic              r_ok;
    logic [SPW-1:0]    r_span;
    logic [AW-1:0]     r_base;
    logic [PW-1:0]     r_ptr;
    logic [LEN_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_pop;
    logic              r_rd_vld;
    logic [2:0]        r_rd_idx;
    logic [7:0]        r_mem_q;
    logic              r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out;

    logic [QW-1:0]     qi;
    logic              qv;
    logic [CW-1:0]     size_raw;
    logic [SPW-1:0]    span_c;
    logic [SPW-1:0]    occ_c;
    logic [SPW-1:0]    free_c;
    logic              len_max_ok;
    logic              ok_c;
    logic [PW-1:0]     n_ptr;
    logic [AW-1:0]     mem_addr;
    logic              cfg_hit;
    logic [QW-1:0]     cfg_qi;

    assign qi = QW'(r_q);
    assign qv = int'(r_q) < NUM_QUEUES;

    always_comb begin
        size_raw = CW'(r_size[r_q]);
        if (size_raw == '0) begin
            span_c = SPW'(1);
        end else if (size_raw > CW'(QUEUE_DEPTH)) begin
            span_c = SPW'(QUEUE_DEPTH);
        end else begin
            span_c = SPW'(size_raw);
        end
        if (r_full[qi]) begin
            occ_c = span_c;
        end else if (r_wr[qi] >= r_rd[qi]) begin
            occ_c = SPW'(r_wr[qi]) - SPW'(r_rd[qi]);
        end else begin
            occ_c = SPW'(r_wr[qi]) + span_c - SPW'(r_rd[qi]);
        end
        free_c     = span_c - occ_c;
        len_max_ok = LW'(r_len) <= LW'(MAX_BLOCK_BYTES);
        case (r_cmd)
            CMD_PUSH: ok_c = qv && len_max_ok && (LW'(r_len) <= LW'(free_c));
            CMD_POP:  ok_c = qv && len_max_ok && (LW'(r_len) <= LW'(occ_c));
            default:  ok_c = qv;
        endcase
    end

    assign n_ptr    = ((SPW'(r_ptr) + SPW'(1)) == r_span) ? '0 : r_ptr + PW'(1);
    assign mem_addr = r_base + AW'(r_ptr);
    assign cfg_hit  = i_cfg_we && (int'(i_cfg_idx) < NUM_QUEUES);
    assign cfg_qi   = QW'(i_cfg_idx);

    assign o_sts.go_push  = ok_c && (r_cmd == CMD_PUSH) && (r_len != '0);
    assign o_sts.go_pop   = ok_c && (r_cmd == CMD_POP) && (r_len != '0);
    assign o_sts.last     = (r_cnt + LEN_W'(1)) == r_len;
    assign o_sts.out_busy = r_out_vld && !i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SIZE_REGS; i++) begin
                r_size[i] <= SIZE_RESET;
            end
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_wr[i]   <= '0;
                r_rd[i]   <= '0;
                r_full[i] <= 1'b0;
            end
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.pop_step;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (cfg_hit) begin
                r_size[i_cfg_idx] <= i_cfg_data;
                r_wr[cfg_qi]      <= '0;
                r_rd[cfg_qi]      <= '0;
                r_full[cfg_qi]    <= 1'b0;
            end
            if (i_cmd.check && qv && (r_cmd == CMD_CLEAR)) begin
                r_wr[qi]   <= '0;
                r_rd[qi]   <= '0;
                r_full[qi] <= 1'b0;
            end
            if (i_cmd.push_step && o_sts.last) begin
                r_wr[qi]   <= n_ptr;
                r_full[qi] <= n_ptr == r_rd[qi];
            end
            if (i_cmd.pop_step && o_sts.last) begin
                r_rd[qi]   <= n_ptr;
                r_full[qi] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len  <= i_s_axis_tdata[LEN_W-1:0];
            r_data <= i_s_axis_tdata[LEN_W +: DATA_W];
            r_cmd  <= i_s_axis_tuser[CMD_W-1:0];
            r_q    <= i_s_axis_tuser[CMD_W +: QID_W];
        end
        if (i_cmd.check) begin
            r_ok   <= ok_c;
            r_span <= span_c;
            r_base <= AW'(qi) * AW'(QUEUE_DEPTH);
            r_ptr  <= (r_cmd == CMD_PUSH) ? r_wr[qi] : r_rd[qi];
            r_cnt  <= '0;
            r_pop  <= '0;
        end
        if (i_cmd.push_step || i_cmd.pop_step) begin
            r_ptr <= n_ptr;
            r_cnt <= r_cnt + LEN_W'(1);
        end
        r_rd_idx <= r_cnt[2:0];
        if (r_rd_vld) begin
            r_pop[8*r_rd_idx +: 8] <= r_mem_q;
        end
        if (i_cmd.out_load) begin
            r_out <= {5'd0,
                      qv && !r_full[qi] && (r_wr[qi] == r_rd[qi]),
                      qv && r_full[qi],
                      r_pop,
                      r_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_step) begin
            r_mem[mem_addr] <= r_data[8*r_cnt[2:0] +: 8];
        end
        r_mem_q <= r_mem[mem_addr];
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

`include "multi_queue_byte_ring_buffer_assert.svh"

    `MQRB_ASSERT_IMP(a_step_ok, i_clk, i_rst_n, i_cmd.push_step || i_cmd.pop_step, r_ok)
    `MQRB_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, i_cmd.push_step || i_cmd.pop_step, r_cnt < r_len)
    `MQRB_ASSERT_IMP(a_ptr_range, i_clk, i_rst_n, i_cmd.push_step || i_cmd.pop_step, SPW'(r_ptr) < r_span)
    `MQRB_ASSERT_IMP(a_full_pos, i_clk, i_rst_n, qv && r_full[qi], r_wr[qi] == r_rd[qi])
    `MQRB_ASSERT_NXT(a_pop_unfull, i_clk, i_rst_n, i_cmd.pop_step && o_sts.last, !r_full[qi])

endmodule

FILE: hw/rtl/multi_queue_byte_ring_buffer.sv
// Multi-queue byte ring buffer: one command at a time, L = bytes the command moves.
// Byte-wide store; the next command is taken only once the current result is loaded for output.
// A new command is taken while the previous result waits on the output.
// Synchronous active-low reset clears positions, full flags and sizes (64); store holds no reset.
// Depends on mqrb_pkg, mqrb_ctrl and mqrb_dp.
module multi_queue_byte_ring_buffer #(
    parameter int NUM_QUEUES      = 4,
    parameter int QUEUE_DEPTH     = 64,
    parameter int MAX_BLOCK_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // length[3:0], push_data[67:4], zero fill [71:68]
    input  logic [mqrb_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // command[1:0], queue_id[3:2]
    input  logic [mqrb_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // accepted[0], pop_data[64:1], is_full[65], queue_empty[66], zero fill [71:67]
    output logic [mqrb_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [mqrb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mqrb_pkg::SIZE_W-1:0]       i_cfg_data
);
    import mqrb_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;

    mqrb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (ctrl_sts),
        .o_cmd           (ctrl_cmd)
    );

    mqrb_dp #(
        .NUM_QUEUES      (NUM_QUEUES),
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (ctrl_cmd),
        .o_sts           (ctrl_sts)
    );

endmodule
